[design/urpd_pkg.sv]
// Package for the relay packet deframer: payload structs and code constants.
// No dependencies.
package urpd_pkg;

   localparam int QueueDepth = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_datagram;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_value;
      logic [2:0]  status;
      logic [15:0] packet_id;
      logic [7:0]  fragment_total;
      logic [7:0]  fragment_index;
      logic [15:0] payload_length;
      logic [1:0]  address_kind;
      logic [15:0] port_number;
      logic        is_last;
   } rsp_type;

   localparam logic [1:0] KIND_ADDR    = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   localparam logic [2:0] ST_WHOLE_IP   = 3'd0;
   localparam logic [2:0] ST_FRAGMENT   = 3'd1;
   localparam logic [2:0] ST_WHOLE_NOIP = 3'd2;
   localparam logic [2:0] ST_BAD_HDR    = 3'd3;
   localparam logic [2:0] ST_TRUNC      = 3'd4;
   localparam logic [2:0] ST_BAD_ATYPE  = 3'd5;
   localparam logic [2:0] ST_BAD_FRAG   = 3'd6;
   localparam logic [2:0] ST_OK         = 3'd0;

   localparam logic [1:0] AK_NONE = 2'd0;
   localparam logic [1:0] AK_DOM  = 2'd1;
   localparam logic [1:0] AK_IPV4 = 2'd2;
   localparam logic [1:0] AK_IPV6 = 2'd3;

   localparam logic [7:0] VERSION_BYTE = 8'h05;
   localparam logic [7:0] TYPE_PACKET  = 8'h02;
   localparam logic [7:0] ATYPE_NONE   = 8'hff;
   localparam logic [7:0] ATYPE_DOMAIN = 8'h00;
   localparam logic [7:0] ATYPE_IPV4   = 8'h01;
   localparam logic [7:0] ATYPE_IPV6   = 8'h02;

   // front-to-back work record: up to one data result and one summary per byte
   typedef struct packed {
      logic    has_data;
      logic    has_sum;
      rsp_type data;
      rsp_type sum;
   } work_type;

endpackage

[design/urpd_front.sv]
// Front end: byte-serial header parser that classifies each byte into results.
// Depends on urpd_pkg.
module urpd_front
   import urpd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   input  req_type  req,
   output work_type work
);

   typedef enum logic [3:0] {
      PH_VER, PH_TYPE, PH_HDR, PH_ATYPE, PH_DLEN, PH_DOMAIN,
      PH_IP, PH_PORT, PH_PAYLOAD, PH_TRAIL, PH_SKIP
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] pid_ff, pid_in;
   logic [7:0]  ftot_ff, ftot_in;
   logic [7:0]  fidx_ff, fidx_in;
   logic [15:0] plen_ff, plen_in;
   logic [15:0] rem_ff, rem_in;
   logic [1:0]  ak_ff, ak_in;
   logic [15:0] port_ff, port_in;
   logic [2:0]  drop_ff, drop_in;
   logic [7:0]  b;

   assign b = req.data_byte;

   always_comb begin
      logic [4:0] nc;
      phase_in = phase_ff; cnt_in = cnt_ff; pid_in = pid_ff; ftot_in = ftot_ff;
      fidx_in = fidx_ff; plen_in = plen_ff; rem_in = rem_ff; ak_in = ak_ff;
      port_in = port_ff; drop_in = drop_ff;
      work = '0;
      nc = cnt_ff + 5'd1;
      case (phase_ff)
         PH_VER: begin
            if (b == VERSION_BYTE) phase_in = PH_TYPE;
            else begin drop_in = ST_BAD_HDR; phase_in = PH_SKIP; end
         end
         PH_TYPE: begin
            if (b == TYPE_PACKET) begin phase_in = PH_HDR; cnt_in = '0; end
            else begin drop_in = ST_BAD_HDR; phase_in = PH_SKIP; end
         end
         PH_HDR: begin
            case (cnt_ff[2:0])
               3'd2, 3'd3: pid_in = {pid_ff[7:0], b};
               3'd4: ftot_in = b;
               3'd5: fidx_in = b;
               3'd6, 3'd7: plen_in = {plen_ff[7:0], b};
               default: ;
            endcase
            cnt_in = nc;
            if (nc >= 5'd8) begin
               cnt_in = '0;
               if (fidx_in == 8'd0) phase_in = PH_ATYPE;
               else begin
                  rem_in = plen_in;
                  phase_in = (plen_in == 16'd0) ? PH_TRAIL : PH_PAYLOAD;
               end
            end
         end
         PH_ATYPE: begin
            cnt_in = '0;
            if (b == ATYPE_NONE) begin
               ak_in = AK_NONE; port_in = '0; rem_in = plen_ff;
               phase_in = (plen_ff == 16'd0) ? PH_TRAIL : PH_PAYLOAD;
            end else if (b == ATYPE_DOMAIN) begin
               ak_in = AK_DOM; phase_in = PH_DLEN;
            end else if (b == ATYPE_IPV4) begin
               ak_in = AK_IPV4; cnt_in = 5'd4; phase_in = PH_IP;
            end else if (b == ATYPE_IPV6) begin
               ak_in = AK_IPV6; cnt_in = 5'd16; phase_in = PH_IP;
            end else begin
               drop_in = ST_BAD_ATYPE; phase_in = PH_SKIP;
            end
         end
         PH_DLEN: begin
            rem_in = {8'd0, b}; cnt_in = '0;
            phase_in = (b == 8'd0) ? PH_PORT : PH_DOMAIN;
         end
         PH_DOMAIN: begin
            rem_in = rem_ff - 16'd1;
            if (rem_in == 16'd0) begin cnt_in = '0; phase_in = PH_PORT; end
         end
         PH_IP: begin
            work.has_data = 1'b1;
            work.data.kind = KIND_ADDR;
            work.data.byte_value = b;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_in == 5'd0) phase_in = PH_PORT;
         end
         PH_PORT: begin
            port_in = {port_ff[7:0], b};
            cnt_in = nc;
            if (nc >= 5'd2) begin
               cnt_in = '0; rem_in = plen_ff;
               phase_in = (plen_ff == 16'd0) ? PH_TRAIL : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            work.has_data = 1'b1;
            work.data.kind = KIND_PAYLOAD;
            work.data.byte_value = b;
            rem_in = rem_ff - 16'd1;
            if (rem_in == 16'd0) phase_in = PH_TRAIL;
         end
         default: ;
      endcase

      if (req.end_of_datagram) begin
         work.has_sum = 1'b1;
         work.sum.kind = KIND_SUMMARY;
         if (drop_in != ST_OK) work.sum.status = drop_in;
         else if (phase_in != PH_TRAIL) work.sum.status = ST_TRUNC;
         else if (ftot_in <= 8'd1)
            work.sum.status = (ak_in >= AK_IPV4) ? ST_WHOLE_IP : ST_WHOLE_NOIP;
         else if (fidx_in >= ftot_in) work.sum.status = ST_BAD_FRAG;
         else work.sum.status = ST_FRAGMENT;
         work.sum.packet_id = pid_in;
         work.sum.fragment_total = ftot_in;
         work.sum.fragment_index = fidx_in;
         work.sum.payload_length = plen_in;
         work.sum.address_kind = ak_in;
         work.sum.port_number = port_in;
         work.sum.is_last = 1'b1;
         phase_in = PH_VER; cnt_in = '0; pid_in = '0; ftot_in = '0; fidx_in = '0;
         plen_in = '0; rem_in = '0; ak_in = '0; port_in = '0; drop_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_VER; cnt_ff <= '0; pid_ff <= '0; ftot_ff <= '0;
         fidx_ff <= '0; plen_ff <= '0; rem_ff <= '0; ak_ff <= '0;
         port_ff <= '0; drop_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in; cnt_ff <= cnt_in; pid_ff <= pid_in;
         ftot_ff <= ftot_in; fidx_ff <= fidx_in; plen_ff <= plen_in;
         rem_ff <= rem_in; ak_ff <= ak_in; port_ff <= port_in;
         drop_ff <= drop_in;
      end
   end

endmodule

[design/urpd_queue.sv]
// Short queue of work records between parser and result emitter.
// Depends on urpd_pkg.
module urpd_queue
   import urpd_pkg::*;
#(
   parameter int Depth = QueueDepth
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  work_type wr_data,
   output logic     full,
   input  logic     rd_en,
   output work_type rd_data,
   output logic     empty
);

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   work_type        mem_ff [Depth];
   logic [AW-1:0]   wp_ff, rp_ff;
   logic [AW:0]     cnt_ff;

   assign full    = (cnt_ff == (AW+1)'(Depth));
   assign empty   = (cnt_ff == '0);
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= (wp_ff == AW'(Depth - 1)) ? '0 : wp_ff + AW'(1);
         if (rd_en) rp_ff <= (rp_ff == AW'(Depth - 1)) ? '0 : rp_ff + AW'(1);
         cnt_ff <= cnt_ff + (AW+1)'(wr_en) - (AW+1)'(rd_en);
      end
   end

endmodule

[design/urpd_back.sv]
// Back end: unpacks a work record into one or two results, held in an output register.
// Depends on urpd_pkg.
module urpd_back
   import urpd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  work_type q_data,
   output logic     q_pop,
   output logic     rsp_empty,
   output rsp_type  rsp,
   input  logic     rsp_pop
);

   logic    valid_ff, valid_in;
   rsp_type out_ff, out_in;
   logic    sum_done_ff, sum_done_in;  // data half of head record already sent
   logic    load;

   // output register is free when empty or being popped
   assign load      = !valid_ff || rsp_pop;
   assign rsp_empty = !valid_ff;
   assign rsp       = out_ff;

   always_comb begin
      valid_in = valid_ff && !rsp_pop;
      out_in = out_ff;
      sum_done_in = sum_done_ff;
      q_pop = 1'b0;
      if (load && !q_empty) begin
         valid_in = q_data.has_data || q_data.has_sum;
         if (q_data.has_data && !sum_done_ff) begin
            out_in = q_data.data;
            if (q_data.has_sum) sum_done_in = 1'b1;
            else q_pop = 1'b1;
         end else begin
            out_in = q_data.sum;
            sum_done_in = 1'b0;
            q_pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0; sum_done_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in; sum_done_ff <= sum_done_in;
      end
      out_ff <= out_in;
   end

endmodule

[design/udp_relay_packet_deframer_core.sv]
// Relay packet deframer top level: parser front, work queue, result back end.
// Depends on urpd_pkg, urpd_front, urpd_queue, urpd_back.
//
// Usage:
//  - Input channel (req_): one datagram byte per transaction, with
//    end_of_datagram on the final byte. Taken when push is high, full low.
//  - Result channel (rsp_): queue style; the oldest result sits on rsp_payload
//    while empty is low and leaves on pop.
//  - Each byte gives zero, one or two results: an address or payload byte
//    and/or, on the last byte, a summary with status and header fields.
//  - Path: with the queue and output register idle, a result is written to the
//    queue, then loaded into the output register, and is visible from there.
//  - Throughput: one byte per cycle while full is low, each byte taken by
//    the parser step; a byte that yields both a data result and a summary
//    occupies the output register twice, so the queue absorbs those bursts.
//  - Receiver stall: results wait in the output register and the queue;
//    full rises when the queue fills and parsing pauses with it.
//  - Reset: synchronous, active high; parser returns to expecting the
//    version byte, queue and output register empty.
module udp_relay_packet_deframer_core
   import urpd_pkg::*;
#(
   parameter int Depth = QueueDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_payload,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_payload
);

   work_type work, q_data;
   logic     q_full, q_empty, q_pop, accept;

   assign full   = q_full;
   assign accept = push && !q_full;

   urpd_front u_front (
      .clock(clock), .reset(reset), .step(accept), .req(req_payload), .work(work)
   );

   // every accepted byte takes a queue slot; records without results drop at the back
   urpd_queue #(.Depth(Depth)) u_queue (
      .clock(clock), .reset(reset), .wr_en(accept), .wr_data(work), .full(q_full),
      .rd_en(q_pop), .rd_data(q_data), .empty(q_empty)
   );

   urpd_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
      .rsp_empty(empty), .rsp(rsp_payload), .rsp_pop(pop)
   );

   // summary results always mark the end
   a_sum_last: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((rsp_payload.kind == KIND_SUMMARY) == rsp_payload.is_last))
      else $error("summary/is_last mismatch");

   // a result held back by the receiver does not change
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_payload)))
      else $error("stalled result changed");

   // queue never pops while empty
   a_q_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue underflow");

endmodule

[tb/tb.sv]
// Testbench for udp_relay_packet_deframer_core: byte-serial datagram stimulus,
// a behavioral deframer predictor and an in-order result scoreboard.
// Depends on urpd_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb;
   import urpd_pkg::*;

   typedef enum logic [3:0] {
      P_VER, P_TYPE, P_HDR, P_ATYPE, P_DLEN, P_DOMAIN, P_IP, P_PORT, P_PAYLOAD,
      P_TRAIL, P_SKIP
   } phase_type;

   localparam int CycleLimit = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    pop = 1'b0;
   logic    full, empty;
   req_type req_payload = '0;
   rsp_type rsp_payload;

   udp_relay_packet_deframer_core dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_payload(req_payload), .empty(empty), .pop(pop),
      .rsp_payload(rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state, mirrors the parser registers
   phase_type   ph;
   logic [4:0]  fcount;
   logic [15:0] pid, plen, remain, port;
   logic [7:0]  ftot, fidx;
   logic [1:0]  akind;
   logic [2:0]  drop;

   rsp_type expected_results[$];
   int      errors = 0;
   int      bytes_sent = 0;
   int      results_seen = 0;
   int      summaries_seen = 0;
   int      cycles = 0;
   bit      hold_off = 1'b0;  // long receiver stall in progress
   bit      gaps_on = 1'b1;   // sender idling enabled

   task automatic clear_parser();
      ph = P_VER; fcount = '0; pid = '0; ftot = '0; fidx = '0; plen = '0;
      remain = '0; akind = AK_NONE; port = '0; drop = ST_OK;
   endtask

   function automatic rsp_type data_result(logic [1:0] k, logic [7:0] b);
      rsp_type r;
      r = '0;
      r.kind = k;
      r.byte_value = b;
      return r;
   endfunction

   task automatic start_payload();
      remain = plen;
      ph = (plen == 16'd0) ? P_TRAIL : P_PAYLOAD;
   endtask

   // advance the parser by one byte and queue what it yields
   task automatic predict_deframe(req_type t);
      logic [7:0] b;
      rsp_type    s;
      b = t.data_byte;
      case (ph)
         P_VER: begin
            if (b == VERSION_BYTE) ph = P_TYPE;
            else begin drop = ST_BAD_HDR; ph = P_SKIP; end
         end
         P_TYPE: begin
            if (b == TYPE_PACKET) begin ph = P_HDR; fcount = '0; end
            else begin drop = ST_BAD_HDR; ph = P_SKIP; end
         end
         P_HDR: begin
            case (fcount)
               5'd2, 5'd3: pid = {pid[7:0], b};
               5'd4: ftot = b;
               5'd5: fidx = b;
               5'd6, 5'd7: plen = {plen[7:0], b};
               default: ;
            endcase
            fcount = fcount + 5'd1;
            if (fcount >= 5'd8) begin
               fcount = '0;
               if (fidx == 8'd0) ph = P_ATYPE;
               else start_payload();
            end
         end
         P_ATYPE: begin
            fcount = '0;
            if (b == ATYPE_NONE) begin
               akind = AK_NONE; port = '0; start_payload();
            end else if (b == ATYPE_DOMAIN) begin
               akind = AK_DOM; ph = P_DLEN;
            end else if (b == ATYPE_IPV4) begin
               akind = AK_IPV4; fcount = 5'd4; ph = P_IP;
            end else if (b == ATYPE_IPV6) begin
               akind = AK_IPV6; fcount = 5'd16; ph = P_IP;
            end else begin
               drop = ST_BAD_ATYPE; ph = P_SKIP;
            end
         end
         P_DLEN: begin
            remain = {8'd0, b};
            fcount = '0;
            ph = (b == 8'd0) ? P_PORT : P_DOMAIN;
         end
         P_DOMAIN: begin
            remain = remain - 16'd1;
            if (remain == 16'd0) begin fcount = '0; ph = P_PORT; end
         end
         P_IP: begin
            expected_results.push_back(data_result(KIND_ADDR, b));
            fcount = fcount - 5'd1;
            if (fcount == 5'd0) ph = P_PORT;
         end
         P_PORT: begin
            port = {port[7:0], b};
            fcount = fcount + 5'd1;
            if (fcount >= 5'd2) begin fcount = '0; start_payload(); end
         end
         P_PAYLOAD: begin
            expected_results.push_back(data_result(KIND_PAYLOAD, b));
            remain = remain - 16'd1;
            if (remain == 16'd0) ph = P_TRAIL;
         end
         default: ;
      endcase
      if (t.end_of_datagram) begin
         s = '0;
         s.kind = KIND_SUMMARY;
         if (drop != ST_OK) s.status = drop;
         else if (ph != P_TRAIL) s.status = ST_TRUNC;
         else if (ftot <= 8'd1) s.status = (akind >= AK_IPV4) ? ST_WHOLE_IP : ST_WHOLE_NOIP;
         else if (fidx >= ftot) s.status = ST_BAD_FRAG;
         else s.status = ST_FRAGMENT;
         s.packet_id = pid;
         s.fragment_total = ftot;
         s.fragment_index = fidx;
         s.payload_length = plen;
         s.address_kind = akind;
         s.port_number = port;
         s.is_last = 1'b1;
         expected_results.push_back(s);
         clear_parser();
      end
   endtask

   // one byte transaction; random bursts and gaps come from the sender side
   // push stays high after the byte so the next one can follow with no gap
   task automatic send_byte(logic [7:0] b, logic last);
      req_type t;
      t.data_byte = b;
      t.end_of_datagram = last;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      push <= 1'b1;
      req_payload <= t;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_deframe(t);
      bytes_sent++;
   endtask

   task automatic send_bytes(logic [7:0] bytes[$]);
      foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
   endtask

   // build a datagram; trail adds that many extra bytes after the payload
   task automatic build_datagram(output logic [7:0] d[$], input logic [7:0] ftot_v,
                                 input logic [7:0] fidx_v, input logic [7:0] atype,
                                 input int plen_v, input int trail);
      logic [15:0] id;
      int          alen;
      id = 16'($urandom);
      d = {VERSION_BYTE, TYPE_PACKET, 8'($urandom), 8'($urandom), id[15:8], id[7:0],
           ftot_v, fidx_v, 8'(plen_v >> 8), 8'(plen_v)};
      if (fidx_v == 0) begin
         d.push_back(atype);
         alen = 0;
         if (atype == ATYPE_DOMAIN) begin
            alen = $urandom_range(0, 6);
            d.push_back(8'(alen));
         end else if (atype == ATYPE_IPV4) alen = 4;
         else if (atype == ATYPE_IPV6) alen = 16;
         repeat (alen) d.push_back(8'($urandom));
         if (atype != ATYPE_NONE) begin
            d.push_back(8'($urandom)); d.push_back(8'($urandom));
         end
      end
      repeat (plen_v) d.push_back(8'($urandom));
      repeat (trail) d.push_back(8'($urandom));
   endtask

   function automatic logic [7:0] random_atype();
      case ($urandom_range(0, 4))
         0: return ATYPE_NONE;
         1: return ATYPE_DOMAIN;
         2: return ATYPE_IPV4;
         3: return ATYPE_IPV6;
         default: return 8'($urandom_range(3, 254));
      endcase
   endfunction

   // sender goes idle, then wait until every expected result has been checked
   task automatic wait_drained();
      push <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // receiver: stalls on a rotating pattern, plus the long hold-off
   always @(posedge clock) begin
      if (reset || hold_off) pop <= 1'b0;
      else case (cycles % 37)
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: pop <= 1'b1;
         default: pop <= ($urandom_range(0, 2) != 0);
      endcase
   end

   // checker: compare every popped result with the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      cycles <= cycles + 1;
      if (!reset && pop && !empty) begin
         results_seen++;
         if (rsp_payload.kind == KIND_SUMMARY) summaries_seen++;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual %h", $time, rsp_payload);
         end else begin
            e = expected_results.pop_front();
            if (rsp_payload !== e) begin
               errors++;
               $display("%0t: mismatch, expected %p actual %p", $time, e, rsp_payload);
            end
         end
      end
      if (cycles >= CycleLimit) begin
         $display("%0t: timeout, %0d results pending", $time, expected_results.size());
         $display("status: fail");
         $finish;
      end
   end

   // directed: header fields at both extremes, every address type, all statuses
   task automatic test_directed();
      logic [7:0] d[$];
      gaps_on = 1'b0;
      build_datagram(d, 8'd1, 8'd0, ATYPE_IPV4, 2, 1); send_bytes(d);
      build_datagram(d, 8'd0, 8'd0, ATYPE_IPV6, 1, 0); send_bytes(d);
      build_datagram(d, 8'd0, 8'd0, ATYPE_DOMAIN, 0, 0); send_bytes(d);
      build_datagram(d, 8'd3, 8'd0, ATYPE_NONE, 1, 0); send_bytes(d);
      build_datagram(d, 8'd255, 8'd254, 8'd0, 2, 2); send_bytes(d);
      build_datagram(d, 8'd2, 8'd255, 8'd0, 0, 0); send_bytes(d);   // index past total
      build_datagram(d, 8'd0, 8'd0, 8'h7e, 1, 0); send_bytes(d);    // unknown atype
      send_bytes({8'h04});                                          // bad version, alone
      send_bytes({VERSION_BYTE});                                   // ends before type
      send_bytes({VERSION_BYTE, 8'h03, 8'h00});                     // bad type
      build_datagram(d, 8'd1, 8'd0, ATYPE_IPV4, 3, 0);
      d = d[0:d.size() - 3]; send_bytes(d);                         // truncated payload
      build_datagram(d, 8'd1, 8'd0, ATYPE_DOMAIN, 0, 0);
      d = d[0:d.size() - 2]; send_bytes(d);                         // port cut short
      send_bytes({VERSION_BYTE, TYPE_PACKET, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h01,
                  8'h00, 8'h01, 8'hab, 8'hff});                     // all-ones id and total
      gaps_on = 1'b1;
      wait_drained();
   endtask

   // random well-formed datagrams, with some cut short and some noise
   task automatic test_random();
      logic [7:0] d[$];
      int         cut;
      while (bytes_sent < 700) begin
         build_datagram(d, 8'($urandom_range(0, 4)),
                        ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 5)) : 8'd0,
                        random_atype(), $urandom_range(0, 6), $urandom_range(0, 2));
         case ($urandom_range(0, 9))
            0: begin cut = $urandom_range(1, d.size()); d = d[0:cut - 1]; end
            1: d[$urandom_range(0, 1)] = 8'($urandom);
            default: ;
         endcase
         send_bytes(d);
      end
      wait_drained();
   endtask

   // receiver holds off long enough for the queue to fill and push to stall
   task automatic test_backpressure();
      logic [7:0] d[$];
      hold_off = 1'b1;
      gaps_on = 1'b0;
      fork
         begin
            build_datagram(d, 8'd1, 8'd0, ATYPE_IPV6, 20, 0);
            send_bytes(d);
         end
         begin
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
      join
      gaps_on = 1'b1;
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      repeat (20) @(posedge clock);
      $display("Sent %0d bytes; checked %0d results, %0d datagram summaries.",
               bytes_sent, results_seen, summaries_seen);
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
